// ===== rtl/rau_pkg.sv =====
package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int DW = 2 * WORD_BITS;
  localparam int KW = $clog2(DW);
  localparam int QDEPTH = 2;
  localparam int QAW = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    ACT_NORM = 3'd0,
    ACT_ADD  = 3'd1,
    ACT_SUB  = 3'd2,
    ACT_MUL  = 3'd3,
    ACT_DIV  = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_MUL3,
    BK_MUL4,
    BK_COMB,
    BK_GCD,
    BK_DIV,
    BK_FIN,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    act_t                 act;
    logic                 div0;
    logic                 cmp_ok;
    logic                 an_neg;
    logic                 ad_neg;
    logic                 bn_neg;
    logic                 bd_neg;
    logic [WORD_BITS-1:0] an_mag;
    logic [WORD_BITS-1:0] ad_mag;
    logic [WORD_BITS-1:0] bn_mag;
    logic [WORD_BITS-1:0] bd_mag;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/rau_front.sv =====
module rau_front
  import rau_pkg::*;
(
  input  logic [2:0]  action,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  output item_t       item
);

  logic [WORD_BITS-1:0] an, ad, bn, bd;
  act_t act;

  assign an = a_num[WORD_BITS-1:0];
  assign ad = a_den[WORD_BITS-1:0];
  assign bn = b_num[WORD_BITS-1:0];
  assign bd = b_den[WORD_BITS-1:0];

  always_comb begin
    case (act_t'(action))
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: act = act_t'(action);
      default: act = ACT_NORM;
    endcase
  end

  always_comb begin
    item.act    = act;
    item.div0   = (ad == '0) || (act != ACT_NORM && bd == '0) ||
                  (act == ACT_DIV && bn == '0);
    item.cmp_ok = (ad != '0) && (bd != '0);
    item.an_neg = an[WORD_BITS-1];
    item.ad_neg = ad[WORD_BITS-1];
    item.bn_neg = bn[WORD_BITS-1];
    item.bd_neg = bd[WORD_BITS-1];
    item.an_mag = an[WORD_BITS-1] ? WORD_BITS'(-an) : an;
    item.ad_mag = ad[WORD_BITS-1] ? WORD_BITS'(-ad) : ad;
    item.bn_mag = bn[WORD_BITS-1] ? WORD_BITS'(-bn) : bn;
    item.bd_mag = bd[WORD_BITS-1] ? WORD_BITS'(-bd) : bd;
  end

endmodule

// ===== rtl/rau_queue.sv =====
module rau_queue
  import rau_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  item_t   din,
  input  logic    pop,
  output item_t   dout,
  output q_stat_t stat
);

  item_t mem [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic [QAW:0] cnt;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  assign dout = mem[rp];
  assign stat.full = (cnt == (QAW+1)'(QDEPTH));
  assign stat.empty = (cnt == '0);

endmodule

// ===== rtl/rau_back.sv =====
module rau_back
  import rau_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_stat_t     qs,
  input  item_t       head,
  output logic        pop,
  output logic        done,
  output logic [31:0] res_num,
  output logic [30:0] res_den,
  output status_t     status,
  output logic        a_less_b,
  output logic        a_equal_b
);

  localparam logic [DW-1:0] LIMIT = DW'(1) << (WORD_BITS - 1);

  bk_state_t state, state_next;
  item_t it;
  logic [DW-1:0] m1, m2, dp, mp;
  logic [DW-1:0] u, v, g, nq, dq;
  logic [DW:0] rn, rd;
  logic [KW-1:0] k, cnt;
  logic neg;

  logic [WORD_BITS-1:0] mul_a, mul_b;
  logic [DW-1:0] prod;
  logic s1, s2, ns, nneg, dneg;
  logic [DW-1:0] nm, n, d;
  logic signed [DW:0] lhs, rhs;
  logic [DW:0] rtn, rtd;
  logic ovf;
  logic [DW-1:0] qsgn;

  // shared multiplier
  always_comb begin
    case (state)
      BK_MUL2: begin
        mul_a = it.bn_mag;
        mul_b = it.ad_mag;
      end
      BK_MUL3: begin
        mul_a = it.ad_mag;
        mul_b = (it.act == ACT_DIV) ? it.bn_mag : it.bd_mag;
      end
      BK_MUL4: begin
        mul_a = it.an_mag;
        mul_b = it.bn_mag;
      end
      default: begin
        mul_a = it.an_mag;
        mul_b = it.bd_mag;
      end
    endcase
  end
  assign prod = DW'(mul_a) * DW'(mul_b);

  // combine cross products
  always_comb begin
    s1 = it.an_neg ^ it.bd_neg;
    s2 = it.bn_neg ^ it.ad_neg ^ (it.act == ACT_SUB);
    if (s1 == s2) begin
      nm = m1 + m2;
      ns = s1;
    end else if (m1 >= m2) begin
      nm = m1 - m2;
      ns = s1;
    end else begin
      nm = m2 - m1;
      ns = s2;
    end
    case (it.act)
      ACT_ADD, ACT_SUB: begin
        n = nm;
        nneg = ns;
        dneg = it.ad_neg ^ it.bd_neg;
        d = dp;
      end
      ACT_MUL: begin
        n = mp;
        nneg = it.an_neg ^ it.bn_neg;
        dneg = it.ad_neg ^ it.bd_neg;
        d = dp;
      end
      ACT_DIV: begin
        n = m1;
        nneg = it.an_neg ^ it.bd_neg;
        dneg = it.ad_neg ^ it.bn_neg;
        d = dp;
      end
      default: begin
        n = DW'(it.an_mag);
        nneg = it.an_neg;
        dneg = it.ad_neg;
        d = DW'(it.ad_mag);
      end
    endcase
    lhs = (it.an_neg ^ it.ad_neg) ? -$signed({1'b0, m1}) : $signed({1'b0, m1});
    rhs = (it.bn_neg ^ it.bd_neg) ? -$signed({1'b0, m2}) : $signed({1'b0, m2});
  end

  assign rtn = {rn[DW-1:0], nq[DW-1]};
  assign rtd = {rd[DW-1:0], dq[DW-1]};
  assign ovf = (neg ? (nq > LIMIT) : (nq >= LIMIT)) || (dq >= LIMIT);
  assign qsgn = neg ? -nq : nq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    done = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!qs.empty) begin
          pop = 1'b1;
          state_next = BK_MUL1;
        end
      end
      BK_MUL1: state_next = BK_MUL2;
      BK_MUL2: state_next = BK_MUL3;
      BK_MUL3: state_next = BK_MUL4;
      BK_MUL4: state_next = BK_COMB;
      BK_COMB: state_next = (it.div0 || n == '0) ? BK_OUT : BK_GCD;
      BK_GCD: if (u == v) state_next = BK_DIV;
      BK_DIV: if (cnt == KW'(DW - 1)) state_next = BK_FIN;
      BK_FIN: state_next = BK_OUT;
      BK_OUT: begin
        done = 1'b1;
        state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: if (!qs.empty) it <= head;
      BK_MUL1: m1 <= prod;
      BK_MUL2: m2 <= prod;
      BK_MUL3: dp <= prod;
      BK_MUL4: mp <= prod;
      BK_COMB: begin
        a_less_b  <= it.cmp_ok && (lhs < rhs);
        a_equal_b <= it.cmp_ok && (lhs == rhs);
        neg <= nneg ^ dneg;
        u <= n;
        v <= d;
        nq <= n;
        dq <= d;
        k <= '0;
        res_num <= '0;
        res_den <= 31'd1;
        status <= it.div0 ? ST_DIV0 : ST_OK;
      end
      BK_GCD: begin
        if (u == v) begin
          g <= u << k;
          rn <= '0;
          rd <= '0;
          cnt <= '0;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 1'b1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u > v) begin
          u <= (u - v) >> 1;
        end else begin
          v <= (v - u) >> 1;
        end
      end
      BK_DIV: begin
        cnt <= cnt + 1'b1;
        if (rtn >= {1'b0, g}) begin
          rn <= rtn - {1'b0, g};
          nq <= {nq[DW-2:0], 1'b1};
        end else begin
          rn <= rtn;
          nq <= {nq[DW-2:0], 1'b0};
        end
        if (rtd >= {1'b0, g}) begin
          rd <= rtd - {1'b0, g};
          dq <= {dq[DW-2:0], 1'b1};
        end else begin
          rd <= rtd;
          dq <= {dq[DW-2:0], 1'b0};
        end
      end
      BK_FIN: begin
        if (ovf) begin
          status <= ST_OVF;
        end else begin
          res_num <= 32'($signed(qsgn[WORD_BITS-1:0]));
          res_den <= 31'(dq[WORD_BITS-2:0]);
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/rational_arith_unit.sv =====
// Exact fraction arithmetic: normalize, add, subtract, multiply or divide two
// 32-bit fractions, reduced by the gcd with the sign on the numerator, plus
// exact less/equal flags. A transaction is taken when start is high and busy
// low; a two-entry queue sits between the input classifier and the execution
// engine, so busy only rises when both entries wait. The engine runs its
// multiplies on one shared 32x32 multiplier, then a binary gcd over the 64-bit
// cross products, then two exact dividers; zero results and divide-by-zero
// skip the gcd and the dividers. Each result shows for one cycle with done
// high and cannot be held off by the receiver.
module rational_arith_unit
  import rau_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  action,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  output logic        done,
  output logic [31:0] res_num,
  output logic [30:0] res_den,
  output logic [1:0]  status,
  output logic        a_less_b,
  output logic        a_equal_b
);

  item_t in_item, head;
  q_stat_t qs;
  logic pop;
  status_t st;

  rau_front u_front (
    .action (action),
    .a_num  (a_num),
    .a_den  (a_den),
    .b_num  (b_num),
    .b_den  (b_den),
    .item   (in_item)
  );

  rau_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (start && !busy),
    .din  (in_item),
    .pop  (pop),
    .dout (head),
    .stat (qs)
  );

  rau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qs        (qs),
    .head      (head),
    .pop       (pop),
    .done      (done),
    .res_num   (res_num),
    .res_den   (res_den),
    .status    (st),
    .a_less_b  (a_less_b),
    .a_equal_b (a_equal_b)
  );

  assign busy = qs.full;
  assign status = st;

  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  assert property (@(posedge clk) disable iff (rst) done |-> res_den != '0)
    else $error("zero denominator on result");
  assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (res_num == '0 && res_den == 31'd1))
    else $error("error result not 0/1");
  assert property (@(posedge clk) disable iff (rst) done |-> !(a_less_b && a_equal_b))
    else $error("less and equal both set");

endmodule

// ===== tb/tb_rational_arith_unit.sv =====
`timescale 1ns / 100ps

module tb_rational_arith_unit;
  import rau_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  action = '0;
  logic [31:0] a_num = '0;
  logic [31:0] a_den = '0;
  logic [31:0] b_num = '0;
  logic [31:0] b_den = '0;
  logic        done;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic [1:0]  status;
  logic        a_less_b;
  logic        a_equal_b;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    status_t     st;
    logic        lt;
    logic        eq;
  } frac_res_t;

  frac_res_t   pending_q[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;

  localparam int unsigned CYCLE_LIMIT = 900000;

  rational_arith_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .done(done), .res_num(res_num), .res_den(res_den), .status(status),
    .a_less_b(a_less_b), .a_equal_b(a_equal_b)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t reduce_fraction(logic [2:0] act_in, logic [31:0] an_w,
                                                logic [31:0] ad_w, logic [31:0] bn_w,
                                                logic [31:0] bd_w);
    logic signed [63:0] an, ad, bn, bd, xa, xb, lhs, rhs;
    logic [63:0] nmag, dmag, p1, p2, g;
    logic nneg, dneg, s1, s2, neg;
    act_t act;
    frac_res_t r;
    an = $signed(an_w);
    ad = $signed(ad_w);
    bn = $signed(bn_w);
    bd = $signed(bd_w);
    act = act_in > ACT_DIV ? ACT_NORM : act_t'(act_in);
    r = '{num: 32'd0, den: 31'd1, st: ST_OK, lt: 1'b0, eq: 1'b0};
    nneg = 1'b0;
    dneg = 1'b0;
    nmag = 0;
    dmag = 1;
    if (ad == 0 || (act != ACT_NORM && bd == 0) || (act == ACT_DIV && bn == 0)) begin
      r.st = ST_DIV0;
    end else begin
      case (act)
        ACT_ADD, ACT_SUB: begin
          s1 = (an < 0) != (bd < 0);
          s2 = (bn < 0) != (ad < 0);
          if (act == ACT_SUB) s2 = !s2;
          p1 = mag64(an) * mag64(bd);
          p2 = mag64(bn) * mag64(ad);
          if (s1 == s2) begin
            nneg = s1;
            nmag = p1 + p2;
          end else if (p1 >= p2) begin
            nneg = s1;
            nmag = p1 - p2;
          end else begin
            nneg = s2;
            nmag = p2 - p1;
          end
          dneg = (ad < 0) != (bd < 0);
          dmag = mag64(ad) * mag64(bd);
        end
        ACT_MUL: begin
          nneg = (an < 0) != (bn < 0);
          nmag = mag64(an) * mag64(bn);
          dneg = (ad < 0) != (bd < 0);
          dmag = mag64(ad) * mag64(bd);
        end
        ACT_DIV: begin
          nneg = (an < 0) != (bd < 0);
          nmag = mag64(an) * mag64(bd);
          dneg = (ad < 0) != (bn < 0);
          dmag = mag64(ad) * mag64(bn);
        end
        default: begin
          nneg = an < 0;
          nmag = mag64(an);
          dneg = ad < 0;
          dmag = mag64(ad);
        end
      endcase
      if (nmag != 0) begin
        g = euclid(nmag, dmag);
        neg = nneg != dneg;
        nmag = nmag / g;
        dmag = dmag / g;
        if ((neg ? nmag > 64'h8000_0000 : nmag >= 64'h8000_0000) ||
            dmag >= 64'h8000_0000) begin
          r.st = ST_OVF;
        end else begin
          r.num = neg ? 32'(-nmag) : nmag[31:0];
          r.den = dmag[30:0];
        end
      end
    end
    if (ad != 0 && bd != 0) begin
      xa = ad < 0 ? -an : an;
      xb = bd < 0 ? -bn : bn;
      lhs = xa * $signed(mag64(bd));
      rhs = xb * $signed(mag64(ad));
      r.lt = lhs < rhs;
      r.eq = lhs == rhs;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, pending_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // check each result transaction against the oldest expectation
  always @(posedge clk) begin
    frac_res_t want;
    if (!rst && done) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result num=%h den=%h", res_num, res_den);
      end else begin
        want = pending_q.pop_front();
        if (res_num !== want.num || res_den !== want.den || status !== want.st ||
            a_less_b !== want.lt || a_equal_b !== want.eq) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want num=%h den=%h st=%0d lt=%b eq=%b, got %h %h %0d %b %b",
                     want.num, want.den, want.st, want.lt, want.eq,
                     res_num, res_den, status, a_less_b, a_equal_b);
        end
      end
    end
  end

  task automatic send_fraction_op(logic [2:0] act, logic [31:0] an, logic [31:0] ad,
                                  logic [31:0] bn, logic [31:0] bd);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6) == 0 ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    action <= act;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(reduce_fraction(act, an, ad, bn, bd));
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20);
      1: return -$urandom_range(0, 20);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      3: return $urandom_range(0, 4000) - 2000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed_extremes();
    send_fraction_op(ACT_NORM, 32'd6, -32'd4, 32'd1, 32'd1);
    send_fraction_op(ACT_NORM, 32'h8000_0000, -32'd1, 32'd0, 32'd0);
    send_fraction_op(ACT_NORM, 32'h8000_0000, 32'h8000_0000, 32'd3, 32'd7);
    send_fraction_op(ACT_NORM, 32'd0, -32'd5, 32'd0, 32'd3);
    send_fraction_op(3'd5, 32'd10, 32'd15, 32'd2, 32'd3);
    send_fraction_op(3'd6, -32'd9, 32'd3, 32'd1, 32'd0);
    send_fraction_op(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_fraction_op(ACT_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_fraction_op(ACT_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    send_fraction_op(ACT_ADD, 32'd1, 32'd2, -32'd1, 32'd2);
    send_fraction_op(ACT_SUB, 32'd3, 32'd4, 32'd1, -32'd4);
    send_fraction_op(ACT_SUB, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
    send_fraction_op(ACT_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_fraction_op(ACT_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_fraction_op(ACT_MUL, 32'd2, 32'd3, -32'd3, 32'd2);
    send_fraction_op(ACT_MUL, 32'd1, 32'd0, 32'd1, 32'd1);
    send_fraction_op(ACT_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
    send_fraction_op(ACT_DIV, 32'd1, 32'd2, 32'd3, 32'd0);
    send_fraction_op(ACT_DIV, 32'h8000_0000, 32'd1, -32'd1, 32'd1);
    send_fraction_op(ACT_DIV, 32'h7fff_ffff, 32'd1, 32'h8000_0000, 32'd1);
    send_fraction_op(ACT_ADD, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe);
    send_fraction_op(ACT_NORM, 32'hffff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h8000_0000);
  endtask

  task automatic test_quiet_pause();
    wait_drained();
    send_fraction_op(ACT_SUB, 32'd5, 32'd7, 32'd5, 32'd7);
    wait_drained();
  endtask

  task automatic test_random_ops(int unsigned n);
    logic [31:0] an, ad, bn, bd;
    for (int unsigned i = 0; i < n; i++) begin
      an = rand_word();
      ad = rand_word();
      bn = rand_word();
      bd = rand_word();
      if ($urandom_range(0, 9) == 0) begin
        bn = an * 3;
        bd = ad * 3;
      end
      send_fraction_op(3'($urandom_range(0, 7)), an, ad, bn, bd);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_quiet_pause();
    test_random_ops(290);
    test_quiet_pause();
    test_random_ops(290);
    wait_drained();
    repeat (250) @(posedge clk);
    $display("covered %0d transactions over all actions, extremes, zero and overflow cases",
             items_sent);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
